// ===== rtl/core/lrps_pkg.sv =====
package lrps_pkg;

    localparam int WORD_BITS = 24;

    // command codes on the input channel
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // register indexes on the configuration port
    localparam logic [2:0] REG_LED_COUNT  = 3'd0;
    localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
    localparam logic [2:0] REG_ONE_LOW    = 3'd2;
    localparam logic [2:0] REG_ZERO_HIGH  = 3'd3;
    localparam logic [2:0] REG_ZERO_LOW   = 3'd4;
    localparam logic [2:0] REG_LATCH      = 3'd5;

    // register reset values
    localparam logic [6:0]  RST_LED_COUNT = 7'd60;
    localparam logic [7:0]  RST_ONE_HIGH  = 8'd10;
    localparam logic [7:0]  RST_ONE_LOW   = 8'd5;
    localparam logic [7:0]  RST_ZERO_HIGH = 8'd5;
    localparam logic [7:0]  RST_ZERO_LOW  = 8'd10;
    localparam logic [15:0] RST_LATCH     = 16'd80;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  pixel_index;
        logic [23:0] pixel_color;
    } t_cmd_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_result;

    typedef struct packed {
        logic [6:0]  led_count;
        logic [7:0]  one_high_ticks;
        logic [7:0]  one_low_ticks;
        logic [7:0]  zero_high_ticks;
        logic [7:0]  zero_low_ticks;
        logic [15:0] latch_ticks;
    } t_cfg;

    typedef enum logic [1:0] {
        K_WRITE,
        K_START,
        K_TICK,
        K_NOP
    } t_kind;

    // classified request as it sits in the queue
    typedef struct packed {
        t_kind       kind;
        logic        idx_ok;
        logic [5:0]  pixel_index;
        logic [23:0] pixel_color;
    } t_qitem;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HIGH,
        PH_LOW,
        PH_LATCH
    } t_phase;

    function automatic logic [7:0] f_at_least_one(input logic [7:0] v);
        f_at_least_one = (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

// ===== rtl/core/led_ring_pulse_serializer.sv =====
// Smart-LED chain driver. Each request is a command: write a 24-bit pixel into
// the store, start a frame, advance the line by one tick, or do nothing; every
// request gives exactly one result carrying the pin level, busy, frame-done and
// rejected flags. Requests are taken one per clock with no bubbles while the
// result side is not stalled; a request passes through the input queue and its
// result is then registered by the serializer, which updates the waveform state
// once per request. After reset the input stalls while the pixel store is swept
// to zero; configuration writes are taken during that sweep. Pixel writes and
// starts that arrive during a frame or its latch gap are dropped and flagged as
// rejected. Write the timing registers only while no frame is running.
module led_ring_pulse_serializer #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // command requests
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lrps_pkg::t_cmd_item i_in_data,

    // results
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lrps_pkg::t_result   o_out_data,

    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    lrps_pkg::t_cfg   r_cfg;
    logic [2:0]       w_reg_idx;
    logic             w_reg_wr;
    logic             w_clearing;
    logic             w_q_valid;
    lrps_pkg::t_qitem w_q_item;
    logic             w_pop;

    // register file: index is the word address
    assign w_reg_idx = paddr[4:2];
    assign w_reg_wr  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count       <= lrps_pkg::RST_LED_COUNT;
            r_cfg.one_high_ticks  <= lrps_pkg::RST_ONE_HIGH;
            r_cfg.one_low_ticks   <= lrps_pkg::RST_ONE_LOW;
            r_cfg.zero_high_ticks <= lrps_pkg::RST_ZERO_HIGH;
            r_cfg.zero_low_ticks  <= lrps_pkg::RST_ZERO_LOW;
            r_cfg.latch_ticks     <= lrps_pkg::RST_LATCH;
        end else if (w_reg_wr) begin
            case (w_reg_idx)
                lrps_pkg::REG_LED_COUNT: begin
                    r_cfg.led_count <= pwdata[6:0];
                end
                lrps_pkg::REG_ONE_HIGH: begin
                    r_cfg.one_high_ticks <= pwdata[7:0];
                end
                lrps_pkg::REG_ONE_LOW: begin
                    r_cfg.one_low_ticks <= pwdata[7:0];
                end
                lrps_pkg::REG_ZERO_HIGH: begin
                    r_cfg.zero_high_ticks <= pwdata[7:0];
                end
                lrps_pkg::REG_ZERO_LOW: begin
                    r_cfg.zero_low_ticks <= pwdata[7:0];
                end
                lrps_pkg::REG_LATCH: begin
                    r_cfg.latch_ticks <= pwdata[15:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            lrps_pkg::REG_LED_COUNT: prdata = {25'd0, r_cfg.led_count};
            lrps_pkg::REG_ONE_HIGH:  prdata = {24'd0, r_cfg.one_high_ticks};
            lrps_pkg::REG_ONE_LOW:   prdata = {24'd0, r_cfg.one_low_ticks};
            lrps_pkg::REG_ZERO_HIGH: prdata = {24'd0, r_cfg.zero_high_ticks};
            lrps_pkg::REG_ZERO_LOW:  prdata = {24'd0, r_cfg.zero_low_ticks};
            lrps_pkg::REG_LATCH:     prdata = {16'd0, r_cfg.latch_ticks};
            default:                 prdata = 32'd0;
        endcase
    end

    // front: decode and queue requests
    lrps_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (w_clearing),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_q_valid  (w_q_valid),
        .o_q_item   (w_q_item),
        .i_pop      (w_pop)
    );

    // back: pixel store, waveform sequencer, result register
    lrps_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_pop       (w_pop),
        .o_clearing  (w_clearing),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/lrps_ram.sv =====
module lrps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lrps_front.sv =====
module lrps_front #(
    parameter int MAX_PIXELS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_hold,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lrps_pkg::t_cmd_item i_in_data,
    output logic                o_q_valid,
    output lrps_pkg::t_qitem    o_q_item,
    input  logic                i_pop
);

    lrps_pkg::t_qitem r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    lrps_pkg::t_qitem w_item;
    logic             w_push;

    // classify the request
    always_comb begin
        w_item.pixel_index = i_in_data.pixel_index;
        w_item.pixel_color = i_in_data.pixel_color;
        w_item.idx_ok      = int'(i_in_data.pixel_index) < MAX_PIXELS;
        case (i_in_data.cmd)
            lrps_pkg::CMD_WRITE: begin
                w_item.kind = lrps_pkg::K_WRITE;
            end
            lrps_pkg::CMD_START: begin
                w_item.kind = lrps_pkg::K_START;
            end
            lrps_pkg::CMD_TICK: begin
                w_item.kind = lrps_pkg::K_TICK;
            end
            default: begin
                w_item.kind = lrps_pkg::K_NOP;
            end
        endcase
    end

    assign o_in_ready = !i_hold && (r_count != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign o_q_valid  = r_count != 2'd0;
    assign o_q_item   = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != 2'd0))
        else $error("queue popped while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

// ===== rtl/core/lrps_back.sv =====
module lrps_back #(
    parameter int MAX_PIXELS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lrps_pkg::t_cfg   i_cfg,
    input  logic             i_q_valid,
    input  lrps_pkg::t_qitem i_q_item,
    output logic             o_pop,
    output logic             o_clearing,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lrps_pkg::t_result o_out_data
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_PIXELS - 1);
    localparam logic [LW-1:0] MAX_LEN   = LW'(MAX_PIXELS);
    localparam logic [4:0]    LAST_BIT  = 5'(lrps_pkg::WORD_BITS - 1);

    lrps_pkg::t_phase  r_phase, n_phase;
    logic [15:0]       r_tick_left, n_tick_left;
    logic [4:0]        r_bit_pos, n_bit_pos;
    logic [AW-1:0]     r_pixel_pos, n_pixel_pos;
    logic [23:0]       r_shift, n_shift;
    logic [23:0]       r_word0;
    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;
    logic              r_out_valid;
    lrps_pkg::t_result r_out, n_out;

    logic              w_fire;
    logic              w_busy;
    logic [15:0]       w_tl;
    logic [23:0]       w_shifted;
    logic [6:0]        w_lc;
    logic [LW-1:0]     w_frame_len;
    logic [LW-1:0]     w_next_pos;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [23:0]       w_wdata;
    logic [23:0]       w_rdata;
    logic              w_pix_write;

    assign w_busy = r_phase != lrps_pkg::PH_IDLE;
    assign w_fire = i_q_valid && !r_clearing && (!r_out_valid || i_out_ready);
    assign o_pop  = w_fire;

    assign w_pix_write = w_fire && (i_q_item.kind == lrps_pkg::K_WRITE) && !w_busy
                         && i_q_item.idx_ok;

    // store: clear sweep after reset, then pixel writes while idle
    assign w_we    = r_clearing || w_pix_write;
    assign w_waddr = r_clearing ? r_clr_addr : AW'(i_q_item.pixel_index);
    assign w_wdata = r_clearing ? 24'd0 : i_q_item.pixel_color;

    // read port always looks one pixel ahead of the one on the line
    lrps_ram #(
        .WIDTH (24),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (AW'(LW'(r_pixel_pos) + LW'(1))),
        .o_rdata (w_rdata)
    );

    assign w_lc        = (i_cfg.led_count == 7'd0) ? 7'd1 : i_cfg.led_count;
    assign w_frame_len = (LW'(w_lc) > MAX_LEN) ? MAX_LEN : LW'(w_lc);
    assign w_next_pos  = LW'(r_pixel_pos) + LW'(1);
    assign w_tl        = (r_tick_left != 16'd0) ? (r_tick_left - 16'd1) : 16'd0;
    assign w_shifted   = {r_shift[22:0], 1'b0};

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_tick_left = r_tick_left;
        n_bit_pos   = r_bit_pos;
        n_pixel_pos = r_pixel_pos;
        n_shift     = r_shift;
        if (w_fire) begin
            case (i_q_item.kind)
                lrps_pkg::K_START: begin
                    if (!w_busy) begin
                        n_pixel_pos = '0;
                        n_bit_pos   = 5'd0;
                        n_shift     = r_word0;
                        n_phase     = lrps_pkg::PH_HIGH;
                        n_tick_left = 16'(lrps_pkg::f_at_least_one(r_word0[23] ?
                                      i_cfg.one_high_ticks : i_cfg.zero_high_ticks));
                    end
                end
                lrps_pkg::K_TICK: begin
                    if (w_busy) begin
                        if (w_tl != 16'd0) begin
                            n_tick_left = w_tl;
                        end else begin
                            case (r_phase)
                                lrps_pkg::PH_HIGH: begin
                                    n_phase     = lrps_pkg::PH_LOW;
                                    n_tick_left = 16'(lrps_pkg::f_at_least_one(r_shift[23] ?
                                                  i_cfg.one_low_ticks : i_cfg.zero_low_ticks));
                                end
                                lrps_pkg::PH_LOW: begin
                                    if (r_bit_pos != LAST_BIT) begin
                                        n_shift     = w_shifted;
                                        n_bit_pos   = r_bit_pos + 5'd1;
                                        n_phase     = lrps_pkg::PH_HIGH;
                                        n_tick_left = 16'(lrps_pkg::f_at_least_one(
                                                      w_shifted[23] ? i_cfg.one_high_ticks
                                                                    : i_cfg.zero_high_ticks));
                                    end else if (w_next_pos < w_frame_len) begin
                                        n_pixel_pos = AW'(w_next_pos);
                                        n_bit_pos   = 5'd0;
                                        n_shift     = w_rdata;
                                        n_phase     = lrps_pkg::PH_HIGH;
                                        n_tick_left = 16'(lrps_pkg::f_at_least_one(
                                                      w_rdata[23] ? i_cfg.one_high_ticks
                                                                  : i_cfg.zero_high_ticks));
                                    end else begin
                                        n_shift   = w_shifted;
                                        n_bit_pos = 5'd0;
                                        if (i_cfg.latch_ticks == 16'd0) begin
                                            n_phase = lrps_pkg::PH_IDLE;
                                        end else begin
                                            n_phase     = lrps_pkg::PH_LATCH;
                                            n_tick_left = i_cfg.latch_ticks;
                                        end
                                    end
                                end
                                lrps_pkg::PH_LATCH: begin
                                    n_phase = lrps_pkg::PH_IDLE;
                                end
                                default: begin
                                    n_phase = r_phase;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // result fields
    always_comb begin
        n_out.line_level = (r_phase == lrps_pkg::PH_HIGH)
                           || ((i_q_item.kind == lrps_pkg::K_START) && !w_busy);
        n_out.busy_res   = n_phase != lrps_pkg::PH_IDLE;
        n_out.frame_done = (i_q_item.kind == lrps_pkg::K_TICK) && w_busy
                           && (n_phase == lrps_pkg::PH_IDLE);
        n_out.rejected   = w_busy && ((i_q_item.kind == lrps_pkg::K_WRITE)
                                      || (i_q_item.kind == lrps_pkg::K_START));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lrps_pkg::PH_IDLE;
            r_tick_left <= 16'd0;
            r_bit_pos   <= 5'd0;
            r_pixel_pos <= '0;
            r_shift     <= 24'd0;
            r_word0     <= 24'd0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_tick_left <= n_tick_left;
            r_bit_pos   <= n_bit_pos;
            r_pixel_pos <= n_pixel_pos;
            r_shift     <= n_shift;
            if (w_pix_write && (i_q_item.pixel_index == 6'd0)) begin
                r_word0 <= i_q_item.pixel_color;
            end
            if (r_clearing) begin
                if (r_clr_addr == LAST_ADDR) begin
                    r_clearing <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_clearing  = r_clearing;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_tick_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != lrps_pkg::PH_IDLE) |-> (r_tick_left != 16'd0))
        else $error("active phase with no ticks left");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_pos <= LAST_BIT)
        else $error("bit position past end of word");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_out_valid)
        else $error("result produced during store clear");

    a_no_store_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_pix_write)
        else $error("pixel store written during a frame");

endmodule

// ===== verif/tb_led_ring_pulse_serializer.sv =====
`timescale 1ns / 1ps

module tb_led_ring_pulse_serializer;

    localparam int MAX_PIX = 64;
    // the package names no code for the fourth command value; the block treats it as a no-op
    localparam logic [1:0] CMD_NOP = 2'd3;

    // ------------------------------------------------------------------
    // clock, reset, block ports
    // ------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    lrps_pkg::t_cmd_item cmd_item = '0;

    logic                res_valid;
    logic                res_ready = 1'b0;
    lrps_pkg::t_result   res_data;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #5 i_clk = ~i_clk;

    led_ring_pulse_serializer #(
        .MAX_PIXELS(MAX_PIX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (cmd_valid),
        .o_in_ready (cmd_ready),
        .i_in_data  (cmd_item),
        .o_out_valid(res_valid),
        .i_out_ready(res_ready),
        .o_out_data (res_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // bookkeeping
    // ------------------------------------------------------------------
    lrps_pkg::t_cmd_item pending_cmds[$];       // requests not yet presented to the block
    lrps_pkg::t_result   expected_results[$];   // predicted results, oldest first
    lrps_pkg::t_result   oldest_expect;
    lrps_pkg::t_result   predicted;
    int        results_outstanding = 0; // sent requests whose result is not checked yet
    int        cmds_sent = 0;
    int        mismatch_count = 0;
    int        send_gap_pct = 37;       // chance per cycle that the driver holds off
    int        recv_stall_pct = 65;     // chance per cycle that the sink drops ready

    // result bit order follows the packed struct, bit 0 first
    string field_name [4] = '{"rejected", "frame_done", "busy_res", "line_level"};

    // ------------------------------------------------------------------
    // line predictor: own copy of registers and waveform state
    // ------------------------------------------------------------------
    lrps_pkg::t_cfg cfg_shadow = '{led_count: lrps_pkg::RST_LED_COUNT,
                                   one_high_ticks: lrps_pkg::RST_ONE_HIGH,
                                   one_low_ticks: lrps_pkg::RST_ONE_LOW,
                                   zero_high_ticks: lrps_pkg::RST_ZERO_HIGH,
                                   zero_low_ticks: lrps_pkg::RST_ZERO_LOW,
                                   latch_ticks: lrps_pkg::RST_LATCH};
    logic [23:0] pix_mem [MAX_PIX] = '{default: '0};
    logic [5:0]  pixel_idx = '0;
    logic [4:0]  bit_idx = '0;
    logic [23:0] shifter = '0;
    lrps_pkg::t_phase ph = lrps_pkg::PH_IDLE;
    logic [15:0] ticks_left = '0;

    // led_count is clamped to 1..MAX_PIX when a pixel ends
    function automatic int frame_pixels();
        int n;
        n = (cfg_shadow.led_count == 7'd0) ? 1 : int'(cfg_shadow.led_count);
        return (n > MAX_PIX) ? MAX_PIX : n;
    endfunction

    // part timing sampled at the start of each part, zero counts as one tick
    task automatic begin_high_part();
        logic [7:0] t;
        t = shifter[23] ? cfg_shadow.one_high_ticks : cfg_shadow.zero_high_ticks;
        ph = lrps_pkg::PH_HIGH;
        ticks_left = (t == 8'd0) ? 16'd1 : {8'd0, t};
    endtask

    task automatic begin_low_part();
        logic [7:0] t;
        t = shifter[23] ? cfg_shadow.one_low_ticks : cfg_shadow.zero_low_ticks;
        ph = lrps_pkg::PH_LOW;
        ticks_left = (t == 8'd0) ? 16'd1 : {8'd0, t};
    endtask

    task automatic load_pixel(input int pos);
        pixel_idx = pos[5:0];
        bit_idx = '0;
        shifter = pix_mem[pos];
        begin_high_part();
    endtask

    // one tick of line time while busy; done marks the end of the frame
    task automatic tick_line(output logic done);
        done = 1'b0;
        if (ticks_left != 16'd0)
            ticks_left = ticks_left - 16'd1;
        if (ticks_left == 16'd0) begin
            case (ph)
                lrps_pkg::PH_HIGH: begin
                    begin_low_part();
                end
                lrps_pkg::PH_LOW: begin
                    shifter = {shifter[22:0], 1'b0};
                    bit_idx = bit_idx + 5'd1;
                    if (bit_idx < lrps_pkg::WORD_BITS) begin
                        begin_high_part();
                    end else if (int'(pixel_idx) + 1 < frame_pixels()) begin
                        load_pixel(int'(pixel_idx) + 1);
                    end else begin
                        bit_idx = '0;
                        // no latch gap: frame ends on the last low tick
                        if (cfg_shadow.latch_ticks == 16'd0) begin
                            ph = lrps_pkg::PH_IDLE;
                            done = 1'b1;
                        end else begin
                            ph = lrps_pkg::PH_LATCH;
                            ticks_left = cfg_shadow.latch_ticks;
                        end
                    end
                end
                default: begin
                    ph = lrps_pkg::PH_IDLE;
                    done = 1'b1;
                end
            endcase
        end
    endtask

    task automatic predict_line_result(input lrps_pkg::t_cmd_item req,
                                       output lrps_pkg::t_result res);
        logic was_busy;
        logic done;
        was_busy = (ph != lrps_pkg::PH_IDLE);
        done = 1'b0;
        res = '0;
        // writes and starts bounce off a running frame
        if (req.cmd == lrps_pkg::CMD_WRITE || req.cmd == lrps_pkg::CMD_START) begin
            if (was_busy)
                res.rejected = 1'b1;
            else if (req.cmd == lrps_pkg::CMD_WRITE)
                pix_mem[req.pixel_index] = req.pixel_color;
            else
                load_pixel(0);
        end
        // a tick reports the level held during it, others the level after the request
        res.line_level = (ph == lrps_pkg::PH_HIGH);
        if (req.cmd == lrps_pkg::CMD_TICK && was_busy)
            tick_line(done);
        res.frame_done = done;
        res.busy_res = (ph != lrps_pkg::PH_IDLE);
    endtask

    // ------------------------------------------------------------------
    // driver: presents queued requests, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_valid <= 1'b0;
        end else begin
            if (cmd_valid && cmd_ready) begin
                predict_line_result(cmd_item, predicted);
                expected_results.push_back(predicted);
            end
            // valid may only change once the current request is gone
            if (!cmd_valid || cmd_ready) begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    cmd_valid <= 1'b1;
                    cmd_item <= pending_cmds.pop_front();
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request pending: %b", res_data);
                    mismatch_count++;
                end else begin
                    oldest_expect = expected_results.pop_front();
                    for (int b = 0; b < 4; b++) begin
                        if (res_data[b] !== oldest_expect[b]) begin
                            $error("%s: expected %0b, got %0b", field_name[b],
                                   oldest_expect[b], res_data[b]);
                            mismatch_count++;
                        end
                    end
                    results_outstanding--;
                end
            end
            res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [1:0] cmd, input logic [5:0] idx,
                            input logic [23:0] color);
        lrps_pkg::t_cmd_item item;
        item.cmd = cmd;
        item.pixel_index = idx;
        item.pixel_color = color;
        pending_cmds.push_back(item);
        results_outstanding++;
        cmds_sent++;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (results_outstanding != 0);
    endtask

    // setup cycle, access cycle; the register takes the value at the access edge
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            lrps_pkg::REG_LED_COUNT: cfg_shadow.led_count = val[6:0];
            lrps_pkg::REG_ONE_HIGH:  cfg_shadow.one_high_ticks = val[7:0];
            lrps_pkg::REG_ONE_LOW:   cfg_shadow.one_low_ticks = val[7:0];
            lrps_pkg::REG_ZERO_HIGH: cfg_shadow.zero_high_ticks = val[7:0];
            lrps_pkg::REG_ZERO_LOW:  cfg_shadow.zero_low_ticks = val[7:0];
            lrps_pkg::REG_LATCH:     cfg_shadow.latch_ticks = val[15:0];
            default: ;
        endcase
    endtask

    // only called with the block idle and nothing in flight
    task automatic program_timing(input int count, input int one_hi, input int one_lo,
                                  input int zero_hi, input int zero_lo, input int latch);
        reg_write(lrps_pkg::REG_LED_COUNT, count);
        reg_write(lrps_pkg::REG_ONE_HIGH, one_hi);
        reg_write(lrps_pkg::REG_ONE_LOW, one_lo);
        reg_write(lrps_pkg::REG_ZERO_HIGH, zero_hi);
        reg_write(lrps_pkg::REG_ZERO_LOW, zero_lo);
        reg_write(lrps_pkg::REG_LATCH, latch);
    endtask

    // tick until the predicted line is idle again; latch gap in one burst
    task automatic finish_frame();
        int batch;
        wait_drained();
        while (ph != lrps_pkg::PH_IDLE) begin
            batch = (ph == lrps_pkg::PH_LATCH) ? int'(ticks_left) : 32;
            repeat (batch) send_cmd(lrps_pkg::CMD_TICK, 6'($urandom()), 24'($urandom()));
            wait_drained();
        end
    endtask

    function automatic logic [23:0] rand_color();
        case ($urandom_range(0, 7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    // mostly short parts so frames stay short
    function automatic int rand_part_ticks();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
    endfunction

    // load a few pixels, start, tick with some noise mixed in, run out the frame
    task automatic random_frame();
        int pick;
        repeat ($urandom_range(0, 4))
            send_cmd(lrps_pkg::CMD_WRITE,
                     6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 3)),
                     rand_color());
        if ($urandom_range(0, 3) == 0)
            send_cmd(($urandom_range(0, 1) != 0) ? CMD_NOP : lrps_pkg::CMD_TICK,
                     6'($urandom()), 24'($urandom()));
        // now and then the start is missing and the ticks just run on an idle line
        if ($urandom_range(0, 7) != 0)
            send_cmd(lrps_pkg::CMD_START, 6'($urandom()), 24'($urandom()));
        repeat ($urandom_range(10, 80)) begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                send_cmd(lrps_pkg::CMD_TICK, 6'($urandom()), 24'($urandom()));
            else if (pick < 90)
                send_cmd(lrps_pkg::CMD_WRITE, 6'($urandom()), rand_color());
            else if (pick < 95)
                send_cmd(lrps_pkg::CMD_START, 6'($urandom()), 24'($urandom()));
            else
                send_cmd(CMD_NOP, 6'($urandom()), 24'($urandom()));
        end
        finish_frame();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int goal;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: two pixels, zero-high part forced to one tick, no latch gap
        program_timing(2, 3, 1, 0, 2, 0);
        send_cmd(lrps_pkg::CMD_WRITE, 6'd0, 24'hFFFFFF);
        send_cmd(lrps_pkg::CMD_WRITE, 6'd63, 24'h000000);
        send_cmd(lrps_pkg::CMD_WRITE, 6'd63, 24'hFFFFFF);
        send_cmd(lrps_pkg::CMD_WRITE, 6'd1, 24'hA5C30F);
        send_cmd(CMD_NOP, 6'd0, 24'h000000);
        send_cmd(lrps_pkg::CMD_TICK, 6'd63, 24'hFFFFFF);      // idle tick, line stays low
        send_cmd(lrps_pkg::CMD_START, 6'd0, 24'h000000);
        send_cmd(lrps_pkg::CMD_START, 6'd0, 24'h000000);      // bounced, frame running
        send_cmd(lrps_pkg::CMD_WRITE, 6'd2, 24'h123456);      // bounced
        send_cmd(CMD_NOP, 6'd63, 24'hFFFFFF);
        send_cmd(lrps_pkg::CMD_TICK, 6'd0, 24'h000000);
        finish_frame();
        send_cmd(lrps_pkg::CMD_TICK, 6'd0, 24'h000000);
        wait_drained();

        // led_count zero acts as one pixel; short latch gap
        program_timing(0, 1, 0, 1, 1, 3);
        send_cmd(lrps_pkg::CMD_START, 6'd0, 24'h000000);
        send_cmd(lrps_pkg::CMD_WRITE, 6'd0, 24'h000000);      // bounced
        finish_frame();

        // random frames under three handshake load patterns
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_gap_pct = 37;
                    recv_stall_pct = 65;
                end
                1: begin
                    send_gap_pct = 65;
                    recv_stall_pct = 37;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            goal = cmds_sent + 220;
            while (cmds_sent < goal) begin
                program_timing($urandom_range(0, 3), rand_part_ticks(), rand_part_ticks(),
                               rand_part_ticks(), rand_part_ticks(), $urandom_range(0, 6));
                repeat ($urandom_range(1, 2)) random_frame();
            end
        end

        // full speed: longest high part, zero timings taken as one tick, single pixel
        program_timing(1, 255, 0, 0, 0, 40);
        send_cmd(lrps_pkg::CMD_WRITE, 6'd0, 24'h800000);
        send_cmd(lrps_pkg::CMD_START, 6'd0, 24'h000000);
        finish_frame();

        wait_drained();
        // then keep the clock running to catch stray results
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hang guard
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lrps_pkg.sv
rtl/core/lrps_ram.sv
rtl/core/lrps_front.sv
rtl/core/lrps_back.sv
rtl/core/led_ring_pulse_serializer.sv
verif/tb_led_ring_pulse_serializer.sv
